// File: rtl/core/sktl_pkg.sv
package sktl_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int CAT_W    = 8;
  localparam int OUT_CNT_W = 11;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } sktl_action_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [CAT_W-1:0] category;
  } sktl_in_t;

  typedef struct packed {
    logic                 accepted;
    logic                 found;
    logic [CAT_W-1:0]     found_category;
    logic [OUT_CNT_W-1:0] entry_count;
  } sktl_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } sktl_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             cmp_en;
    logic             shift_en;
    logic [KEY_W-1:0] key;
    logic [CAT_W-1:0] category;
  } sktl_cmd_t;

endpackage

// File: rtl/core/sorted_key_table_lookup.sv
// each item passes through the compare and apply states; the out_valid strobe is registered
// as the apply state ends, and busy is high while the compare and apply states last
// one item at a time: a new item is taken only after the compare and shift pass over
// the row of cells that keeps the table sorted
// synchronous active-low reset empties the table at once; no clearing pass
// results are strobed for one cycle and cannot be stalled
module sorted_key_table_lookup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sktl_pkg::sktl_in_t  in_data,
  output logic                out_valid,
  output sktl_pkg::sktl_out_t out_data
);
  import sktl_pkg::*;

  sktl_state_t state_r, state_nxt;
  sktl_in_t    req_r;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] uniq_r;
  logic        out_valid_r;
  sktl_out_t   out_data_r;

  sktl_cmd_t   cmd;
  logic        full;
  logic        dup;
  logic [CAT_W-1:0] hit_cat;

  logic             gt_w    [CAPACITY];
  logic             eq_w    [CAPACITY];
  logic             valid_w [CAPACITY];
  logic [KEY_W-1:0] key_w   [CAPACITY];
  logic [CAT_W-1:0] cat_w   [CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        sktl_cell u_cell (
          .clk(clk), .rst_n(rst_n), .cmd(cmd),
          .left_gt(1'b0), .left_valid(1'b0),
          .left_key('0), .left_cat('0),
          .gt(gt_w[gi]), .eq(eq_w[gi]), .valid(valid_w[gi]),
          .key(key_w[gi]), .cat(cat_w[gi])
        );
      end else begin : g_rest
        sktl_cell u_cell (
          .clk(clk), .rst_n(rst_n), .cmd(cmd),
          .left_gt(gt_w[gi-1]), .left_valid(valid_w[gi-1]),
          .left_key(key_w[gi-1]), .left_cat(cat_w[gi-1]),
          .gt(gt_w[gi]), .eq(eq_w[gi]), .valid(valid_w[gi]),
          .key(key_w[gi]), .cat(cat_w[gi])
        );
      end
    end
  endgenerate

  // at most one cell matches since the chain holds no duplicates
  always_comb begin
    dup     = 1'b0;
    hit_cat = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      dup     = dup | eq_w[i];
      hit_cat = hit_cat | (eq_w[i] ? cat_w[i] : '0);
    end
  end

  assign full = (used_r == CNT_W'(CAPACITY));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.key      = req_r.key;
    cmd.category = req_r.category;
    busy         = 1'b1;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_CMP:   cmd.cmp_en = 1'b1;
      ST_APPLY: cmd.shift_en = (req_r.action == ACT_INSERT) && !full && !dup;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      uniq_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_APPLY);
      if (state_r == ST_APPLY) begin
        if (req_r.action == ACT_INSERT) begin
          if (!full) begin
            used_r <= used_r + 1'b1;
            if (!dup) uniq_r <= uniq_r + 1'b1;
          end
        end else begin
          // lookup drops the duplicates still counted
          used_r <= uniq_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) req_r <= in_data;
    if (state_r == ST_APPLY) begin
      if (req_r.action == ACT_INSERT) begin
        out_data_r.accepted       <= !full;
        out_data_r.found          <= 1'b0;
        out_data_r.found_category <= '0;
        out_data_r.entry_count    <= OUT_CNT_W'(full ? used_r : used_r + 1'b1);
      end else begin
        out_data_r.accepted       <= 1'b1;
        out_data_r.found          <= dup;
        out_data_r.found_category <= hit_cat;
        out_data_r.entry_count    <= OUT_CNT_W'(uniq_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/sktl_cell.sv
module sktl_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sktl_pkg::sktl_cmd_t           cmd,
  input  logic                          left_gt,
  input  logic                          left_valid,
  input  logic [sktl_pkg::KEY_W-1:0]    left_key,
  input  logic [sktl_pkg::CAT_W-1:0]    left_cat,
  output logic                          gt,
  output logic                          eq,
  output logic                          valid,
  output logic [sktl_pkg::KEY_W-1:0]    key,
  output logic [sktl_pkg::CAT_W-1:0]    cat
);
  import sktl_pkg::*;

  logic             gt_r;
  logic             eq_r;
  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [CAT_W-1:0] cat_r;

  // an empty cell counts as holding a key above everything
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r    <= 1'b0;
      eq_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (cmd.cmp_en) begin
        gt_r <= !valid_r || (key_r > cmd.key);
        eq_r <= valid_r && (key_r == cmd.key);
      end
      if (cmd.shift_en && gt_r) begin
        valid_r <= left_gt ? left_valid : 1'b1;
      end
    end
  end

  // cells above the insertion point take their left neighbor's entry
  always_ff @(posedge clk) begin
    if (cmd.shift_en && gt_r) begin
      key_r <= left_gt ? left_key : cmd.key;
      cat_r <= left_gt ? left_cat : cmd.category;
    end
  end

  assign gt    = gt_r;
  assign eq    = eq_r;
  assign valid = valid_r;
  assign key   = key_r;
  assign cat   = cat_r;

endmodule

// File: dv/tb_sorted_key_table_lookup.sv
`timescale 1ns / 1ps

module tb_sorted_key_table_lookup;
  import sktl_pkg::*;

  class lookup_scoreboard;
    logic [KEY_W-1:0] keys[$];
    logic [CAT_W-1:0] cats[$];
    bit               table_sorted;
    sktl_out_t        pending[$];
    int               mismatches;

    function new();
      table_sorted = 0;
      mismatches   = 0;
    endfunction

    // stable insertion sort, then keep the earliest of each key
    function void sort_table();
      logic [KEY_W-1:0] k;
      logic [CAT_W-1:0] c;
      logic [KEY_W-1:0] nk[$];
      logic [CAT_W-1:0] nc[$];
      int j;
      for (int i = 1; i < keys.size(); i++) begin
        k = keys[i];
        c = cats[i];
        j = i;
        while (j > 0 && keys[j-1] > k) begin
          keys[j] = keys[j-1];
          cats[j] = cats[j-1];
          j--;
        end
        keys[j] = k;
        cats[j] = c;
      end
      foreach (keys[i]) begin
        if (i == 0 || keys[i] != nk[nk.size()-1]) begin
          nk.push_back(keys[i]);
          nc.push_back(cats[i]);
        end
      end
      keys = nk;
      cats = nc;
      table_sorted = 1;
    endfunction

    function void note_word(sktl_in_t w);
      sktl_out_t r;
      r = '0;
      r.accepted = 1'b1;
      if (w.action == ACT_INSERT) begin
        if (keys.size() < CAPACITY) begin
          keys.push_back(w.key);
          cats.push_back(w.category);
          table_sorted = 0;
        end else begin
          r.accepted = 1'b0;
        end
      end else begin
        if (!table_sorted) sort_table();
        foreach (keys[i]) begin
          if (keys[i] == w.key) begin
            r.found = 1'b1;
            r.found_category = cats[i];
          end
        end
      end
      r.entry_count = OUT_CNT_W'(keys.size());
      pending.push_back(r);
    endfunction

    function void check_word(sktl_out_t got);
      sktl_out_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.accepted !== exp.accepted || got.found !== exp.found ||
          got.found_category !== exp.found_category ||
          got.entry_count !== exp.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp acc=%0d fnd=%0d cat=%0d cnt=%0d",
                    " got acc=%0d fnd=%0d cat=%0d cnt=%0d"},
                   exp.accepted, exp.found, exp.found_category, exp.entry_count,
                   got.accepted, got.found, got.found_category, got.entry_count);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  sktl_in_t  in_data = '0;
  logic      out_valid;
  sktl_out_t out_data;

  lookup_scoreboard sb = new();
  int n_ins, n_look, n_hit;
  logic [KEY_W-1:0] key_pool[$];

  sorted_key_table_lookup u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (out_data.found) n_hit++;
      sb.check_word(out_data);
    end
  end

  // start stays high when there is no gap so the next word follows at once
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(logic act, logic [KEY_W-1:0] k, logic [CAT_W-1:0] c);
    sktl_in_t w;
    w.action   = act;
    w.key      = k;
    w.category = c;
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
    if (act == ACT_INSERT) begin
      n_ins++;
      key_pool.push_back(k);
    end else n_look++;
    idle_gap();
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return KEY_W'($urandom_range(0, 40));
      2: return {32'hffffffff, $urandom_range(0, 40)};
      default: return key_pool.size() ? key_pool[$urandom_range(0, key_pool.size()-1)]
                                      : {$urandom, $urandom};
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates
    send_word(ACT_LOOKUP, '0, 8'hff);
    send_word(ACT_INSERT, '1, 8'hff);
    send_word(ACT_INSERT, '0, 8'h00);
    send_word(ACT_INSERT, 64'h5555_5555_aaaa_aaaa, 8'h5a);
    send_word(ACT_INSERT, 64'h5555_5555_aaaa_aaaa, 8'ha5);
    send_word(ACT_INSERT, '1, 8'h01);
    send_word(ACT_LOOKUP, '1, 8'h00);
    send_word(ACT_LOOKUP, '0, 8'h00);
    send_word(ACT_LOOKUP, 64'h5555_5555_aaaa_aaaa, 8'h00);
    send_word(ACT_LOOKUP, 64'haaaa_aaaa_5555_5555, 8'hff);
    send_word(ACT_INSERT, 64'h8000_0000_0000_0000, 8'h80);
    send_word(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, 8'h7f);
    send_word(ACT_LOOKUP, 64'h8000_0000_0000_0000, 8'h00);
    send_word(ACT_LOOKUP, 64'h7fff_ffff_ffff_ffff, 8'h00);
    drain();

    for (int i = 0; i < 800; i++) begin
      if (i == 400) drain();
      send_word($urandom_range(0, 2) == 0 ? ACT_LOOKUP : ACT_INSERT,
                rand_key(), CAT_W'($urandom_range(0, 255)));
    end

    // fill to capacity with distinct keys, then overflow
    for (int i = 0; sb.keys.size() < CAPACITY; i++)
      send_word(ACT_INSERT, {32'h1234_0000, i[31:0]}, i[7:0]);
    for (int i = 0; i < 4; i++)
      send_word(ACT_INSERT, {32'h1234_ffff, i[31:0]}, i[7:0]);
    send_word(ACT_LOOKUP, {32'h1234_0000, 32'd3}, 8'h00);
    for (int i = 0; i < 6; i++)
      send_word(ACT_INSERT, rand_key(), CAT_W'($urandom_range(0, 255)));
    for (int i = 0; i < 20; i++) send_word(ACT_LOOKUP, rand_key(), 8'h00);
    drain();

    $display("covered %0d inserts and %0d lookups (%0d hits), incl. table-full refusals",
             n_ins, n_look, n_hit);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end
endmodule
